[src/cas_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk access statistics package
// Shared constants, payload structs, controller state and control structs.
// ----------------------------------------------------------------------------
package cas_pkg;

    // Default sizes of the statistics stores.
    localparam int DEF_NUM_CHUNKS       = 4096;
    localparam int DEF_COUNT_WIDTH      = 32;
    localparam int DEF_SECTOR_SUM_WIDTH = 48;

    // Fixed field widths of the request and response.
    localparam int LBA_W     = 48;
    localparam int SIZE_W    = 16;
    localparam int IDX_OUT_W = 12;
    localparam int WIN_W     = 13;
    localparam int CNT_OUT_W = 32;
    localparam int SUM_OUT_W = 48;

    // Chunk size register and the address shift it controls.
    localparam int                   CFG_W               = 4;
    localparam logic [CFG_W-1:0]     CFG_RESET           = 4'd8;
    localparam int                   SHIFT_W             = 5;
    localparam logic [SHIFT_W-1:0]   SECTORS_PER_MB_LOG2 = 5'd11;

    // Distinct chunk count holds at its largest value.
    localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};

    typedef struct packed {
        logic [LBA_W-1:0]  lba;
        logic [SIZE_W-1:0] size_sectors;
        logic              is_write;
    } t_req;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] chunk_index;
        logic                 out_of_range;
        logic                 first_in_window;
        logic [WIN_W-1:0]     window_chunks;
        logic [CNT_OUT_W-1:0] total_requests;
        logic [SUM_OUT_W-1:0] total_sectors;
        logic [CNT_OUT_W-1:0] chunk_requests;
        logic [CNT_OUT_W-1:0] chunk_reads;
        logic [CNT_OUT_W-1:0] chunk_writes;
        logic [SUM_OUT_W-1:0] chunk_sectors;
        logic [SUM_OUT_W-1:0] chunk_read_sectors;
        logic [SUM_OUT_W-1:0] chunk_write_sectors;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic update;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[src/cas_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read; a read at the written address returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/cas_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk access statistics controller
// Sequences the clearing pass and the read-modify-write of each request.
// ----------------------------------------------------------------------------
module cas_ctrl
    import cas_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/cas_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk access statistics datapath
// Chunk mapping, global counters, per-chunk stores and the response register.
// ----------------------------------------------------------------------------
module cas_datapath
    import cas_pkg::*;
#(
    parameter int NUM_CHUNKS       = DEF_NUM_CHUNKS,
    parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH,
    parameter int SECTOR_SUM_WIDTH = DEF_SECTOR_SUM_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_req             i_req,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output t_rsp                  o_rsp,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts
);

    localparam int AW = $clog2(NUM_CHUNKS);
    localparam int CW = COUNT_WIDTH;
    localparam int SW = SECTOR_SUM_WIDTH;

    // Saturating increment of a request counter.
    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] a);
        logic [CW:0] s;
        s = {1'b0, a} + (CW+1)'(1);
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    // Saturating addition of a request length to a sector sum.
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
                                              input logic [SIZE_W-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + (SW+1)'(b);
        return s[SW] ? {SW{1'b1}} : s[SW-1:0];
    endfunction

    // Configuration and captured request.
    logic [CFG_W-1:0]     r_cfg;
    logic [SIZE_W-1:0]    r_size;
    logic                 r_wr;
    logic [IDX_OUT_W-1:0] r_idx_lo;
    logic                 r_oor;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        r_clr_addr;

    // Global statistics.
    logic [CW-1:0]    r_all_req, r_rd_req, r_wr_req;
    logic [SW-1:0]    r_all_sec, r_rd_sec, r_wr_sec;
    logic [WIN_W-1:0] r_win_cnt;

    logic r_rsp_valid;
    t_rsp r_rsp;

    // Chunk mapping of the incoming request.
    logic [SHIFT_W-1:0] shift;
    logic [LBA_W-1:0]   chunk_full;

    assign shift      = SHIFT_W'(r_cfg) + SECTORS_PER_MB_LOG2;
    assign chunk_full = i_req.lba >> shift;

    // Store ports.
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic [3*CW-1:0] cnt_rdata, cnt_wdata;
    logic [3*SW-1:0] sec_rdata, sec_wdata;
    logic            seen_rdata, seen_wdata;

    assign mem_addr = i_cmd.clear ? r_clr_addr : r_addr;
    assign mem_we   = i_cmd.clear || (i_cmd.update && !r_oor);

    cas_ram #(.WIDTH(3*CW), .DEPTH(NUM_CHUNKS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (cnt_wdata),
        .i_raddr (mem_addr),
        .o_rdata (cnt_rdata)
    );

    cas_ram #(.WIDTH(3*SW), .DEPTH(NUM_CHUNKS)) u_sec_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (sec_wdata),
        .i_raddr (mem_addr),
        .o_rdata (sec_rdata)
    );

    cas_ram #(.WIDTH(1), .DEPTH(NUM_CHUNKS)) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (seen_wdata),
        .i_raddr (mem_addr),
        .o_rdata (seen_rdata)
    );

    // Per-chunk update from the stored values.
    logic [CW-1:0]    c_all, c_rd, c_wr;
    logic [SW-1:0]    s_all, s_rd, s_wr;
    logic             first;
    logic [WIN_W-1:0] n_win_cnt;

    always_comb begin
        c_all = sat_inc(cnt_rdata[CW-1:0]);
        c_rd  = cnt_rdata[2*CW-1:CW];
        c_wr  = cnt_rdata[3*CW-1:2*CW];
        s_all = sat_add(sec_rdata[SW-1:0], r_size);
        s_rd  = sec_rdata[2*SW-1:SW];
        s_wr  = sec_rdata[3*SW-1:2*SW];
        if (r_wr) begin
            c_wr = sat_inc(c_wr);
            s_wr = sat_add(s_wr, r_size);
        end else begin
            c_rd = sat_inc(c_rd);
            s_rd = sat_add(s_rd, r_size);
        end
        first     = !r_oor && !seen_rdata;
        n_win_cnt = r_win_cnt;
        if (first && (r_win_cnt != WIN_MAX)) begin
            n_win_cnt = r_win_cnt + WIN_W'(1);
        end
    end

    // The clearing pass writes zeros.
    assign cnt_wdata  = i_cmd.clear ? '0 : {c_wr, c_rd, c_all};
    assign sec_wdata  = i_cmd.clear ? '0 : {s_wr, s_rd, s_all};
    assign seen_wdata = !i_cmd.clear;

    // Control registers, configuration and global counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_clr_addr  <= '0;
            r_all_req   <= '0;
            r_rd_req    <= '0;
            r_wr_req    <= '0;
            r_all_sec   <= '0;
            r_rd_sec    <= '0;
            r_wr_sec    <= '0;
            r_win_cnt   <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.update) begin
                r_all_req <= sat_inc(r_all_req);
                r_all_sec <= sat_add(r_all_sec, r_size);
                if (r_wr) begin
                    r_wr_req <= sat_inc(r_wr_req);
                    r_wr_sec <= sat_add(r_wr_sec, r_size);
                end else begin
                    r_rd_req <= sat_inc(r_rd_req);
                    r_rd_sec <= sat_add(r_rd_sec, r_size);
                end
                r_win_cnt <= n_win_cnt;
            end
            if (i_cmd.update) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Request capture and response register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_size   <= i_req.size_sectors;
            r_wr     <= i_req.is_write;
            r_idx_lo <= chunk_full[IDX_OUT_W-1:0];
            r_oor    <= chunk_full >= LBA_W'(NUM_CHUNKS);
            r_addr   <= chunk_full[AW-1:0];
        end
        if (i_cmd.update) begin
            r_rsp.chunk_index     <= r_idx_lo;
            r_rsp.out_of_range    <= r_oor;
            r_rsp.first_in_window <= first;
            r_rsp.window_chunks   <= n_win_cnt;
            r_rsp.total_requests  <= CNT_OUT_W'(sat_inc(r_all_req));
            r_rsp.total_sectors   <= SUM_OUT_W'(sat_add(r_all_sec, r_size));
            if (r_oor) begin
                r_rsp.chunk_requests      <= '0;
                r_rsp.chunk_reads         <= '0;
                r_rsp.chunk_writes        <= '0;
                r_rsp.chunk_sectors       <= '0;
                r_rsp.chunk_read_sectors  <= '0;
                r_rsp.chunk_write_sectors <= '0;
            end else begin
                r_rsp.chunk_requests      <= CNT_OUT_W'(c_all);
                r_rsp.chunk_reads         <= CNT_OUT_W'(c_rd);
                r_rsp.chunk_writes        <= CNT_OUT_W'(c_wr);
                r_rsp.chunk_sectors       <= SUM_OUT_W'(s_all);
                r_rsp.chunk_read_sectors  <= SUM_OUT_W'(s_rd);
                r_rsp.chunk_write_sectors <= SUM_OUT_W'(s_wr);
            end
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_rsp_valid      = r_rsp_valid;
    assign o_rsp            = r_rsp;
    assign o_sts.clear_last = (r_clr_addr == AW'(NUM_CHUNKS - 1));
    assign o_sts.out_free   = !r_rsp_valid || i_rsp_ready;

endmodule

`default_nettype wire

[src/chunk_access_statistics_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk access statistics
// Counts requests and sectors globally and per chunk, and tracks the
// distinct chunks touched in the current window.
//
// Requests enter on the i_req channel (valid/ready) and one response per
// request leaves on the o_rsp channel (valid/ready). The chunk size register
// is written through the i_cfg channel, which is always ready.
// Each request is a read-modify-write of one row of the per-chunk RAMs,
// in order: accept, the registered RAM read, and the update that loads
// the response register. A new request is taken only once the previous one
// has been updated. When the receiver stalls, the response register holds its
// transaction and the update of the following request waits for it.
// After reset the block sweeps the per-chunk stores to zero, one row a cycle,
// over all NUM_CHUNKS rows; no request is accepted during this pass, while
// configuration writes are taken as ever.
// ----------------------------------------------------------------------------
module chunk_access_statistics_top
    import cas_pkg::*;
#(
    parameter int NUM_CHUNKS       = DEF_NUM_CHUNKS,
    parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH,
    parameter int SECTOR_SUM_WIDTH = DEF_SECTOR_SUM_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire t_req             i_req,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing of the clearing pass and of each request.
    cas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Counters, stores and the response register.
    cas_datapath #(
        .NUM_CHUNKS       (NUM_CHUNKS),
        .COUNT_WIDTH      (COUNT_WIDTH),
        .SECTOR_SUM_WIDTH (SECTOR_SUM_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire
